>>> hdl/wnms_pkg.sv
package wnms_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int DIM_W        = 11;
    localparam int COORD_W      = 10;
    localparam int COUNT_W      = 21;
    localparam int CFG_IDX_W    = 2;
    localparam int WINDOW       = 7;
    localparam int HALF         = WINDOW / 2;
    localparam int LINES        = WINDOW - 1;
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int SLOT_W       = $clog2(LINES);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd400;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // per-item bookkeeping that travels alongside the sample
    typedef struct packed {
        logic               center_valid;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               last;
        logic [COUNT_W-1:0] count_above;
    } wnms_meta_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v < DIM_W'(WINDOW)) begin
            r = DIM_W'(WINDOW);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> hdl/wnms_ram.sv
module wnms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read and write at the same address return the old word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/wnms_scan.sv
module wnms_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  wnms_pkg::sample_t             sample,
    input  wnms_pkg::sample_t             threshold,
    input  logic [wnms_pkg::DIM_W-1:0]    image_width,
    input  logic [wnms_pkg::DIM_W-1:0]    image_height,
    output logic [wnms_pkg::ADDR_W-1:0]   col_addr,
    output logic [wnms_pkg::SLOT_W-1:0]   slot,
    output wnms_pkg::wnms_meta_t          meta
);
    import wnms_pkg::*;

    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [COUNT_W-1:0] above_reg;

    logic [DIM_W-1:0]   w_use;
    logic [DIM_W-1:0]   h_use;
    logic               col_wrap;
    logic               row_wrap;
    logic [COUNT_W-1:0] above_next;
    logic               center_ok;

    assign w_use = clamp_dim(image_width, DIM_W'(MAX_WIDTH));
    assign h_use = clamp_dim(image_height, DIM_W'(HEIGHT_LIMIT));

    // a counter at or past the last column/row wraps as if it were the last
    assign col_wrap = ({1'b0, col_reg} + DIM_W'(1)) >= w_use;
    assign row_wrap = ({1'b0, row_reg} + DIM_W'(1)) >= h_use;

    assign above_next = (sample > threshold) ? sat_inc(above_reg) : above_reg;
    assign center_ok  = (col_reg >= COORD_W'(LINES)) && (row_reg >= COORD_W'(LINES));

    always_comb begin
        meta.center_valid = center_ok;
        meta.center_x     = center_ok ? col_reg - COORD_W'(HALF) : '0;
        meta.center_y     = center_ok ? row_reg - COORD_W'(HALF) : '0;
        meta.last         = col_wrap && row_wrap;
        meta.count_above  = above_next;
    end

    assign col_addr = ADDR_W'(col_reg);
    assign slot     = slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            slot_reg  <= '0;
            above_reg <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                col_reg <= '0;
                if (row_wrap) begin
                    row_reg   <= '0;
                    slot_reg  <= '0;
                    above_reg <= '0;
                end else begin
                    row_reg   <= row_reg + COORD_W'(1);
                    slot_reg  <= (slot_reg == SLOT_W'(LINES - 1)) ? '0 : slot_reg + SLOT_W'(1);
                    above_reg <= above_next;
                end
            end else begin
                col_reg   <= col_reg + COORD_W'(1);
                above_reg <= above_next;
            end
        end
    end

endmodule

>>> hdl/wnms_line_buf.sv
module wnms_line_buf (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic                          wr_en,
    input  logic [wnms_pkg::ADDR_W-1:0]   addr,
    input  logic [wnms_pkg::SLOT_W-1:0]   wr_slot,
    input  wnms_pkg::sample_t             wr_data,
    input  logic [wnms_pkg::SLOT_W-1:0]   rd_slot,
    output wnms_pkg::sample_t             column_o [wnms_pkg::LINES]
);
    import wnms_pkg::*;

    logic [SAMPLE_W-1:0] rd_data [LINES];

    // one RAM per buffered line, selected by row modulo the line count
    for (genvar k = 0; k < LINES; k++) begin : g_line
        wnms_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (wr_en && (wr_slot == SLOT_W'(k))),
            .waddr (addr),
            .wdata (wr_data),
            .re    (rd_en),
            .raddr (addr),
            .rdata (rd_data[k])
        );
    end

    // oldest line first: window row r comes from RAM (slot + r) mod lines
    always_comb begin
        logic [SLOT_W:0] sum;
        logic [SLOT_W-1:0] idx;
        for (int r = 0; r < LINES; r++) begin
            sum = {1'b0, rd_slot} + (SLOT_W + 1)'(r);
            idx = (sum >= (SLOT_W + 1)'(LINES)) ? SLOT_W'(sum - (SLOT_W + 1)'(LINES))
                                                : SLOT_W'(sum);
            column_o[r] = sample_t'(rd_data[idx]);
        end
    end

endmodule

>>> hdl/wnms_window.sv
module wnms_window (
    input  logic              aclk,
    input  logic              shift_en,
    input  wnms_pkg::sample_t column_i [wnms_pkg::WINDOW],
    input  wnms_pkg::sample_t threshold,
    output logic              peak
);
    import wnms_pkg::*;

    sample_t win_reg [WINDOW][WINDOW];

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int r = 0; r < WINDOW; r++) begin
                for (int c = 0; c < WINDOW - 1; c++) begin
                    win_reg[r][c] <= win_reg[r][c + 1];
                end
                win_reg[r][WINDOW - 1] <= column_i[r];
            end
        end
    end

    // ties keep the center, any strictly greater neighbor suppresses it
    always_comb begin
        sample_t center;
        center = win_reg[HALF][HALF];
        peak   = center > threshold;
        for (int r = 0; r < WINDOW; r++) begin
            for (int c = 0; c < WINDOW; c++) begin
                if (win_reg[r][c] > center) begin
                    peak = 1'b0;
                end
            end
        end
    end

endmodule

>>> hdl/window_non_max_suppression.sv
// 7x7 non-maximum suppression over a raster stream of signed 32-bit corner
// responses. One item goes in and one result comes out per pixel, at a
// sustained rate of one item per clock while m_ready holds. Each item takes
// line RAM read, window shift and peak compare into the result register.
// Six 1024-word line RAMs, each with one write and one registered read per
// cycle, hold the previous rows. Centers within three pixels of the border
// are reported with center_valid low. Running counts restart after the
// result with frame_done high. The line RAMs need no clearing after reset.
// Configuration may be written only while the block is empty.
module window_non_max_suppression (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [wnms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wnms_pkg::SAMPLE_W-1:0]  cfg_data,
    // input item channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [31:0]             s_sample,
    // result item channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_center_valid,
    output logic [9:0]                     m_center_x,
    output logic [9:0]                     m_center_y,
    output logic                           m_is_peak,
    output logic [20:0]                    m_count_above,
    output logic [20:0]                    m_count_peaks,
    output logic                           m_frame_done
);
    import wnms_pkg::*;

    // configuration registers
    sample_t          threshold_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // stage enables: each stage moves when the next is empty or moving
    logic en_out;
    logic en_s2;
    logic en_s1;
    logic accept;

    // scan counters
    logic [ADDR_W-1:0] col_addr;
    logic [SLOT_W-1:0] slot;
    wnms_meta_t        scan_meta;

    // stage 1: waiting on line RAM read data
    logic              s1_valid_reg;
    wnms_meta_t        s1_meta_reg;
    sample_t           s1_sample_reg;
    logic [SLOT_W-1:0] s1_slot_reg;

    // stage 2: window holds this item's neighborhood
    logic       s2_valid_reg;
    wnms_meta_t s2_meta_reg;

    // result register
    logic               out_valid_reg;
    wnms_meta_t         out_meta_reg;
    logic               out_peak_reg;
    logic [COUNT_W-1:0] out_peaks_reg;

    logic [COUNT_W-1:0] peak_total_reg;
    logic [COUNT_W-1:0] peak_total_next;

    sample_t line_col [LINES];
    sample_t win_col  [WINDOW];
    logic    win_peak;
    logic    peak_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
            width_reg     <= DIM_RESET;
            height_reg    <= DIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= sample_t'(cfg_data);
                REG_WIDTH:     width_reg     <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:    height_reg    <= cfg_data[DIM_W-1:0];
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    assign en_out  = !out_valid_reg || m_ready;
    assign en_s2   = !s2_valid_reg || en_out;
    assign en_s1   = !s1_valid_reg || en_s2;
    assign s_ready = en_s1;
    assign accept  = s_valid && en_s1;

    // column/row counters and the running above-threshold count
    wnms_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .sample       (s_sample),
        .threshold    (threshold_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .col_addr     (col_addr),
        .slot         (slot),
        .meta         (scan_meta)
    );

    // the new sample overwrites the oldest line at the same column it reads
    wnms_line_buf u_line_buf (
        .aclk     (aclk),
        .rd_en    (en_s1),
        .wr_en    (accept),
        .addr     (col_addr),
        .wr_slot  (slot),
        .wr_data  (s_sample),
        .rd_slot  (s1_slot_reg),
        .column_o (line_col)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en_s1) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_s1) begin
            s1_meta_reg   <= scan_meta;
            s1_sample_reg <= s_sample;
            s1_slot_reg   <= slot;
        end
    end

    // the window's new right column: buffered rows on top, live sample last
    always_comb begin
        for (int r = 0; r < LINES; r++) begin
            win_col[r] = line_col[r];
        end
        win_col[LINES] = s1_sample_reg;
    end

    wnms_window u_window (
        .aclk      (aclk),
        .shift_en  (en_s2 && s1_valid_reg),
        .column_i  (win_col),
        .threshold (threshold_reg),
        .peak      (win_peak)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en_s2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_s2) begin
            s2_meta_reg <= s1_meta_reg;
        end
    end

    // peaks only count at full-window centers
    assign peak_now        = s2_meta_reg.center_valid && win_peak;
    assign peak_total_next = peak_now ? sat_inc(peak_total_reg) : peak_total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            peak_total_reg <= '0;
        end else if (en_out) begin
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg) begin
                peak_total_reg <= s2_meta_reg.last ? '0 : peak_total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            out_meta_reg  <= s2_meta_reg;
            out_peak_reg  <= peak_now;
            out_peaks_reg <= peak_total_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_center_valid = out_meta_reg.center_valid;
    assign m_center_x     = out_meta_reg.center_x;
    assign m_center_y     = out_meta_reg.center_y;
    assign m_is_peak      = out_peak_reg;
    assign m_count_above  = out_meta_reg.count_above;
    assign m_count_peaks  = out_peaks_reg;
    assign m_frame_done   = out_meta_reg.last;

endmodule

>>> hdl/wnms_checker.sv
module wnms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_center_valid,
    input logic [9:0]  m_center_x,
    input logic [9:0]  m_center_y,
    input logic        m_is_peak,
    input logic [20:0] m_count_above,
    input logic [20:0] m_count_peaks,
    input logic        m_frame_done
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_count_peaks)
            && $stable(m_count_above) && $stable(m_is_peak) && $stable(m_frame_done))
        else $error("result changed while stalled");

    // border pixels report no center and no peak
    a_border: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_center_valid |-> !m_is_peak && m_center_x == 10'd0
            && m_center_y == 10'd0)
        else $error("non-center result carries center data");

    // a peak is always included in the peak count
    a_peak_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_peak |-> m_count_peaks != 21'd0)
        else $error("peak flagged with zero peak count");

    // an accepted item shows up at the output when the output keeps moving
    a_fill_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready ##1 m_ready [*2] |=> m_valid)
        else $error("accepted item did not reach the output");

    // no result is left over from before reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind window_non_max_suppression wnms_checker u_wnms_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_center_valid (m_center_valid),
    .m_center_x     (m_center_x),
    .m_center_y     (m_center_y),
    .m_is_peak      (m_is_peak),
    .m_count_above  (m_count_above),
    .m_count_peaks  (m_count_peaks),
    .m_frame_done   (m_frame_done)
);

>>> tb/sv/tb_top.sv
module tb_top;
    import wnms_pkg::*;

    localparam int CLK_HALF     = 5;
    // line ram read, window shift, compare into the result register
    localparam int LATENCY      = 3;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int MAX_REPORTS  = 100;
    // index 3 decodes to no register, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum {GEN_FULL, GEN_TIES, GEN_SPIKES} sample_mix_t;

    // one result item as the block presents it
    typedef struct packed {
        logic               center_valid;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               is_peak;
        logic [COUNT_W-1:0] count_above;
        logic [COUNT_W-1:0] count_peaks;
        logic               frame_done;
    } nms_result_t;

    // streaming 7x7 peak finder mirrored item by item, plus the queue of
    // results it owes the block's output
    class nms_scoreboard;
        sample_t            row_buf [LINES*MAX_WIDTH];
        sample_t            win [WINDOW][WINDOW];
        int unsigned        col_pos, row_pos;
        logic [COUNT_W-1:0] above_cnt, peak_cnt;
        sample_t            thr_reg;
        logic [DIM_W-1:0]   width_reg, height_reg;
        nms_result_t        expected_results[$];
        int unsigned        n_items, n_results, n_centers, n_peaks, n_frames, n_errors;

        function new();
            foreach (row_buf[i]) row_buf[i] = '0;
            foreach (win[r, c]) win[r][c] = '0;
            col_pos    = 0;
            row_pos    = 0;
            above_cnt  = '0;
            peak_cnt   = '0;
            thr_reg    = '0;
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
        endfunction

        function int unsigned dim_in_use(logic [DIM_W-1:0] v, int unsigned hi);
            if (v < WINDOW) return WINDOW;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned width_in_use();
            return dim_in_use(width_reg, MAX_WIDTH);
        endfunction

        function bit at_frame_start();
            return col_pos == 0 && row_pos == 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
            case (idx)
                REG_THRESHOLD: thr_reg    = data;
                REG_WIDTH:     width_reg  = data[DIM_W-1:0];
                REG_HEIGHT:    height_reg = data[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // accepted input item: advance the window and queue its result
        function void take_sample(sample_t s);
            int unsigned w, h, cidx, slot;
            int          r, c;
            sample_t     column [WINDOW];
            sample_t     centre;
            nms_result_t res;
            w    = width_in_use();
            h    = dim_in_use(height_reg, HEIGHT_LIMIT);
            cidx = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
            slot = row_pos % LINES;
            for (r = 0; r < LINES; r++) begin
                column[r] = row_buf[((slot + r) % LINES) * MAX_WIDTH + cidx];
            end
            column[LINES] = s;
            row_buf[slot * MAX_WIDTH + cidx] = s;
            for (r = 0; r < WINDOW; r++) begin
                for (c = 0; c < WINDOW - 1; c++) win[r][c] = win[r][c+1];
                win[r][WINDOW-1] = column[r];
            end
            if (s > thr_reg && above_cnt != COUNT_MAX) above_cnt++;
            res = '0;
            res.center_valid = col_pos >= LINES && row_pos >= LINES;
            if (res.center_valid) begin
                centre = win[HALF][HALF];
                res.is_peak = centre > thr_reg;
                for (r = 0; r < WINDOW; r++) begin
                    for (c = 0; c < WINDOW; c++) begin
                        if (win[r][c] > centre) res.is_peak = 1'b0;
                    end
                end
                if (res.is_peak && peak_cnt != COUNT_MAX) peak_cnt++;
                res.center_x = COORD_W'(col_pos - HALF);
                res.center_y = COORD_W'(row_pos - HALF);
                n_centers++;
                n_peaks += res.is_peak;
            end
            res.frame_done  = (col_pos + 1 >= w) && (row_pos + 1 >= h);
            res.count_above = above_cnt;
            res.count_peaks = peak_cnt;
            expected_results = {expected_results, res};
            n_items++;
            if (col_pos + 1 >= w) begin
                col_pos = 0;
                if (row_pos + 1 >= h) begin
                    row_pos   = 0;
                    above_cnt = '0;
                    peak_cnt  = '0;
                    n_frames++;
                end else begin
                    row_pos++;
                end
            end else begin
                col_pos++;
            end
        endfunction

        function void mismatch(string field, longint exp_v, longint got_v);
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
            end else if (n_errors == MAX_REPORTS + 1) begin
                $display("%0t: further mismatches not shown", $time);
            end
        endfunction

        function void check_result(nms_result_t got);
            nms_result_t exp_r;
            if (expected_results.size() == 0) begin
                mismatch("unexpected result, count_above", -1, got.count_above);
                return;
            end
            exp_r = expected_results.pop_front();
            n_results++;
            if (got.center_valid !== exp_r.center_valid)
                mismatch("center_valid", exp_r.center_valid, got.center_valid);
            if (got.center_x !== exp_r.center_x)
                mismatch("center_x", exp_r.center_x, got.center_x);
            if (got.center_y !== exp_r.center_y)
                mismatch("center_y", exp_r.center_y, got.center_y);
            if (got.is_peak !== exp_r.is_peak)
                mismatch("is_peak", exp_r.is_peak, got.is_peak);
            if (got.count_above !== exp_r.count_above)
                mismatch("count_above", exp_r.count_above, got.count_above);
            if (got.count_peaks !== exp_r.count_peaks)
                mismatch("count_peaks", exp_r.count_peaks, got.count_peaks);
            if (got.frame_done !== exp_r.frame_done)
                mismatch("frame_done", exp_r.frame_done, got.frame_done);
        endfunction

        function void flush_check();
            if (expected_results.size() != 0) begin
                mismatch("results never delivered", 0, expected_results.size());
            end
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SAMPLE_W-1:0]  cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    sample_t              s_sample  = '0;
    logic                 m_ready   = 1'b0;

    logic               s_ready;
    logic               m_valid;
    logic               m_center_valid;
    logic [COORD_W-1:0] m_center_x;
    logic [COORD_W-1:0] m_center_y;
    logic               m_is_peak;
    logic [COUNT_W-1:0] m_count_above;
    logic [COUNT_W-1:0] m_count_peaks;
    logic               m_frame_done;

    nms_scoreboard sb = new();
    nms_result_t   got;
    int            quiet_cycles = 0;
    int            burst_left   = 0;
    logic [9:0]    rx_tick      = '0;

    // full-scale and bit-pattern samples sent first after reset
    sample_t extreme_vals [12] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                   32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555,
                                   32'hAAAA_AAAA, 32'h8000_0001, 32'h7FFF_FFFE,
                                   32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF};

    window_non_max_suppression dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_center_valid (m_center_valid),
        .m_center_x     (m_center_x),
        .m_center_y     (m_center_y),
        .m_is_peak      (m_is_peak),
        .m_count_above  (m_count_above),
        .m_count_peaks  (m_count_peaks),
        .m_frame_done   (m_frame_done)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // receiver back-pressure, cycling through four moods in turn:
    // always ready, coin flip, mostly stalled, short periodic stalls
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 10'd1;
        case (rx_tick[9:8])
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= 1'($urandom_range(0, 1));
            2'd2:    m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rx_tick[3:0] < 4'd11);
        endcase
    end

    // result checking and handshake watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_center_valid, m_center_x, m_center_y, m_is_peak,
                        m_count_above, m_count_peaks, m_frame_done};
                sb.check_result(got);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("[window_non_max_suppression] ERROR");
        $finish;
    end

    // sender in bursts of random length with random gaps in between
    task automatic send_sample(sample_t v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_sample(v);
        burst_left--;
    endtask

    function automatic sample_t make_sample(sample_mix_t mix);
        sample_t v;
        case (mix)
            // narrow range, so plateaus and equal neighbours are common
            GEN_TIES: v = sample_t'(int'($urandom_range(0, 6)) - 3);
            // low background with isolated spikes and full-scale values
            GEN_SPIKES: begin
                case ($urandom_range(0, 15))
                    0:       v = $urandom;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h8000_0000;
                    3, 4:    v = $urandom_range(1000, 100000);
                    default: v = sample_t'(int'($urandom_range(0, 200)) - 100);
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // n items, then optionally on until the frame closes; valid drops at the end
    task automatic feed(int unsigned n, sample_mix_t mix, bit to_frame_end);
        int unsigned i;
        for (i = 0; i < n; i++) send_sample(make_sample(mix));
        while (to_frame_end && !sb.at_frame_start()) send_sample(make_sample(mix));
        s_valid <= 1'b0;
    endtask

    // wait for every owed result, then let the pipeline settle
    task automatic drain();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (LATENCY + 3) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        sb.set_register(idx, data);
        cfg_wr_en <= 1'b0;
    endtask

    // dimension with junk in the unused upper data bits
    function automatic logic [SAMPLE_W-1:0] dim_word(logic [DIM_W-1:0] d);
        logic [SAMPLE_W-1:0] w;
        w = $urandom;
        w[DIM_W-1:0] = d;
        return w;
    endfunction

    // mostly small frames, some below the window size, a few wider
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 7))
            0:       return DIM_W'($urandom_range(0, 6));
            1:       return DIM_W'($urandom_range(25, 70));
            default: return DIM_W'($urandom_range(7, 20));
        endcase
    endfunction

    function automatic sample_t pick_threshold(int unsigned step_no);
        sample_t t;
        if (step_no == 0) begin
            t = 32'h8000_0000;
        end else if (step_no == 1) begin
            t = 32'h7FFF_FFFF;
        end else begin
            case ($urandom_range(0, 4))
                0:       t = '0;
                1:       t = sample_t'(int'($urandom_range(0, 8)) - 4);
                2:       t = $urandom;
                3:       t = $urandom_range(0, 5000);
                default: t = sample_t'(-int'($urandom_range(0, 5000)));
            endcase
        end
        return t;
    endfunction

    initial begin
        int unsigned      step_no;
        int unsigned      random_items;
        int unsigned      n;
        logic [DIM_W-1:0] wd, hd;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: threshold 0, 400x400; full-scale samples first,
        // then a short run of tied values along the first row
        foreach (extreme_vals[i]) send_sample(extreme_vals[i]);
        feed(20, GEN_TIES, 1'b0);
        drain();

        // shrink the frame mid-row: the column is already past the new last
        // column, so the first row ends with the next item; row 7 is the last
        cfg_write(REG_HEIGHT, dim_word(DIM_W'(8)));
        cfg_write(REG_WIDTH, dim_word(DIM_W'(20)));
        cfg_write(REG_UNUSED, $urandom);
        feed(150, GEN_SPIKES, 1'b0);

        // random settings between short runs, often stopping mid-frame;
        // the first two runs use the threshold extremes
        step_no      = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            drain();
            wd = pick_dim();
            hd = pick_dim();
            // mid-frame the row may only shrink, so windows never pick up
            // line entries this frame has not written
            if (!sb.at_frame_start() && sb.dim_in_use(wd, MAX_WIDTH) > sb.width_in_use()) begin
                wd = DIM_W'(sb.width_in_use());
            end
            if (step_no < 2 || $urandom_range(0, 2) != 0)
                cfg_write(REG_THRESHOLD, pick_threshold(step_no));
            if (step_no < 2 || $urandom_range(0, 2) != 0)
                cfg_write(REG_WIDTH, dim_word(wd));
            if (step_no < 2 || $urandom_range(0, 2) != 0)
                cfg_write(REG_HEIGHT, dim_word(hd));
            if ($urandom_range(0, 9) == 0)
                cfg_write(REG_UNUSED, $urandom);
            n = $urandom_range(20, 180);
            feed(n, sample_mix_t'($urandom_range(0, 2)), 1'b0);
            random_items += n;
            step_no++;
        end

        // drop to the smallest frame and close it so the width can grow
        drain();
        cfg_write(REG_WIDTH, dim_word(DIM_W'(WINDOW)));
        cfg_write(REG_HEIGHT, dim_word(DIM_W'(WINDOW)));
        feed(0, GEN_FULL, 1'b1);
        drain();

        // dimensions beyond the limits clamp to 1024: a short run along
        // the first row of the widest frame
        cfg_write(REG_THRESHOLD, 32'd50);
        cfg_write(REG_WIDTH, dim_word(11'h7FF));
        cfg_write(REG_HEIGHT, dim_word(DIM_W'(1500)));
        feed(40, GEN_SPIKES, 1'b0);
        drain();

        // width 0 clamps to 7: the row ends at once, then 7-wide rows
        // deep enough that centers get evaluated
        cfg_write(REG_THRESHOLD, 32'd0);
        cfg_write(REG_WIDTH, dim_word(DIM_W'(0)));
        feed(60, GEN_TIES, 1'b0);
        drain();

        sb.flush_check();
        $display("run: %0d items in, %0d results checked, %0d frames completed",
                 sb.n_items, sb.n_results, sb.n_frames);
        $display("run: %0d window centers evaluated, %0d peaks, %0d mismatches",
                 sb.n_centers, sb.n_peaks, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("[window_non_max_suppression] OK");
        end else begin
            $display("[window_non_max_suppression] ERROR");
        end
        $finish;
    end

endmodule
